// ===== hdl/ble_pkg.sv =====
// Breathing LED envelope package: widths, reset values, register indexes,
// shaping table and divide-by-255 helper. Depends on nothing.
package ble_pkg;

  localparam int TimeW  = 32;
  localparam int DurW   = 16;
  localparam int TotW   = 18;
  localparam int LvlW   = 8;
  localparam int CfgAw  = 3;
  localparam int NumCells = TimeW;

  localparam logic [DurW-1:0] RiseRst = 16'd1500;
  localparam logic [DurW-1:0] HighRst = 16'd500;
  localparam logic [DurW-1:0] FallRst = 16'd1500;
  localparam logic [DurW-1:0] LowRst  = 16'd500;
  localparam logic [LvlW-1:0] MasterRst = 8'd255;
  localparam logic [LvlW-1:0] FactorMax = 8'd255;
  localparam logic [LvlW-1:0] FactorMin = 8'd5;

  typedef enum logic [CfgAw-1:0] {
    REG_RISE   = 3'd0,
    REG_HIGH   = 3'd1,
    REG_FALL   = 3'd2,
    REG_LOW    = 3'd3,
    REG_MASTER = 3'd4,
    REG_RED    = 3'd5,
    REG_GREEN  = 3'd6,
    REG_BLUE   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_RISE = 2'd0,
    PH_HIGH = 2'd1,
    PH_FALL = 2'd2,
    PH_LOW  = 2'd3
  } phase_t;

  // x/255 for x <= 255*255: exact via (x + 1 + (x >> 8)) >> 8
  function automatic logic [LvlW-1:0] div255(input logic [2*LvlW-1:0] x);
    logic [2*LvlW+1:0] s;
    s = {2'b00, x} + 18'd1 + {10'd0, x[2*LvlW-1:LvlW]};
    return s[LvlW+7:LvlW];
  endfunction

  function automatic logic [LvlW-1:0] shape(input logic [LvlW-1:0] p);
    logic [LvlW-1:0]   q;
    logic [2*LvlW-1:0] m;
    q = div255({8'd0, p} * {8'd0, p});
    m = {8'd0, q} * 16'd250;
    return FactorMin + div255(m);
  endfunction

endpackage

// ===== hdl/ble_mod_cell.sv =====
// One restoring-modulo cell: conditionally subtracts the cycle length
// shifted left by Shift bit positions. Depends on ble_pkg.
module ble_mod_cell #(
  parameter int Shift = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vld_in,
  input  logic                         adv,
  input  logic [ble_pkg::TimeW-1:0]    rem_in,
  input  logic [ble_pkg::TotW-1:0]     tot,
  output logic                         vld_out,
  output logic [ble_pkg::TimeW-1:0]    rem_out
);

  logic [ble_pkg::TimeW+ble_pkg::TotW-1:0] sub_w;
  logic [ble_pkg::TimeW-1:0] rem_nxt;
  logic vld_r;
  logic [ble_pkg::TimeW-1:0] rem_r;

  always_comb begin
    sub_w = {{ble_pkg::TimeW{1'b0}}, tot} << Shift;
    if (tot != '0 && {{ble_pkg::TotW{1'b0}}, rem_in} >= sub_w) begin
      rem_nxt = rem_in - sub_w[ble_pkg::TimeW-1:0];
    end else begin
      rem_nxt = rem_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
    if (adv) begin
      rem_r <= rem_nxt;
    end
  end

  assign vld_out = vld_r;
  assign rem_out = rem_r;

endmodule

// ===== hdl/ble_shaper.sv =====
// Phase decode, progress division, shaping and master scaling of the reduced position.
// Depends on ble_pkg.
module ble_shaper (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_in,
  input  logic                      adv,
  input  logic [ble_pkg::TotW-1:0]  pos,
  input  logic [ble_pkg::DurW-1:0]  rise,
  input  logic [ble_pkg::DurW-1:0]  high,
  input  logic [ble_pkg::DurW-1:0]  fall,
  input  logic [ble_pkg::LvlW-1:0]  master,
  output logic                      vld_out,
  output logic [ble_pkg::LvlW-1:0]  factor,
  output logic [ble_pkg::LvlW-1:0]  drive,
  output logic [1:0]                phase
);

  localparam int NumW = ble_pkg::TotW + ble_pkg::LvlW;
  localparam int QW   = ble_pkg::LvlW + 1;

  // stage A: phase select and numerator
  logic                      a_vld_r;
  logic [1:0]                a_ph_r;
  logic [NumW-1:0]           a_num_r;
  logic [ble_pkg::DurW-1:0]  a_den_r;
  logic [1:0]                a_ph_nxt;
  logic [ble_pkg::TotW-1:0]  off;
  logic [ble_pkg::DurW-1:0]  den;
  logic [ble_pkg::TotW-1:0]  e_rise, e_high, e_fall;

  always_comb begin
    e_rise = {2'b00, rise};
    e_high = e_rise + {2'b00, high};
    e_fall = e_high + {2'b00, fall};
    off = '0;
    den = rise;
    if (pos < e_rise) begin
      a_ph_nxt = ble_pkg::PH_RISE;
      off = pos;
    end else if (pos < e_high) begin
      a_ph_nxt = ble_pkg::PH_HIGH;
    end else if (pos < e_fall) begin
      a_ph_nxt = ble_pkg::PH_FALL;
      off = pos - e_high;
      den = fall;
    end else begin
      a_ph_nxt = ble_pkg::PH_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= vld_in;
    end
    if (adv) begin
      a_ph_r  <= a_ph_nxt;
      a_num_r <= {off, 8'd0} - {8'd0, off};
      a_den_r <= den;
    end
  end

  // restoring divide, one quotient bit per stage; quotient < 256 in rise and fall phases
  logic [QW:1]               d_vld_r;
  logic [1:0]                d_ph_r  [1:QW];
  logic [NumW-1:0]           d_rem_r [1:QW];
  logic [ble_pkg::DurW-1:0]  d_den_r [1:QW];
  logic [QW-1:0]             d_q_r   [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    logic                      vld_i;
    logic [1:0]                ph_i;
    logic [NumW-1:0]           rem_i;
    logic [ble_pkg::DurW-1:0]  den_i;
    logic [QW-1:0]             q_i;
    logic [NumW+QW-1:0]        sh;
    logic                      ge;
    if (k == 0) begin : g_head
      assign vld_i = a_vld_r;
      assign ph_i  = a_ph_r;
      assign rem_i = a_num_r;
      assign den_i = a_den_r;
      assign q_i   = '0;
    end else begin : g_link
      assign vld_i = d_vld_r[k];
      assign ph_i  = d_ph_r[k];
      assign rem_i = d_rem_r[k];
      assign den_i = d_den_r[k];
      assign q_i   = d_q_r[k];
    end
    assign sh = {{QW{1'b0}}, {(NumW-ble_pkg::DurW){1'b0}}, den_i} << B;
    assign ge = {{QW{1'b0}}, rem_i} >= sh;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_vld_r[k+1] <= 1'b0;
      end else if (adv) begin
        d_vld_r[k+1] <= vld_i;
      end
      if (adv) begin
        d_ph_r[k+1]  <= ph_i;
        d_den_r[k+1] <= den_i;
        d_rem_r[k+1] <= ge ? rem_i - sh[NumW-1:0] : rem_i;
        d_q_r[k+1]   <= q_i | (QW'(ge) << B);
      end
    end
  end

  // stage S: shaping table
  logic                     s_vld_r;
  logic [1:0]               s_ph_r;
  logic [ble_pkg::LvlW-1:0] s_fac_r;
  logic [ble_pkg::LvlW-1:0] s_fac_nxt;
  logic [ble_pkg::LvlW-1:0] prog;

  always_comb begin
    prog = d_q_r[QW][ble_pkg::LvlW-1:0];
    unique case (d_ph_r[QW])
      ble_pkg::PH_RISE: s_fac_nxt = ble_pkg::shape(prog);
      ble_pkg::PH_HIGH: s_fac_nxt = ble_pkg::FactorMax;
      ble_pkg::PH_FALL: s_fac_nxt = ble_pkg::shape(ble_pkg::FactorMax - prog);
      default:          s_fac_nxt = ble_pkg::FactorMin;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (adv) begin
      s_vld_r <= d_vld_r[QW];
    end
    if (adv) begin
      s_ph_r  <= d_ph_r[QW];
      s_fac_r <= s_fac_nxt;
    end
  end

  // stage M: master scaling
  logic                      m_vld_r;
  logic [1:0]                m_ph_r;
  logic [ble_pkg::LvlW-1:0]  m_fac_r;
  logic [2*ble_pkg::LvlW-1:0] m_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= s_vld_r;
    end
    if (adv) begin
      m_ph_r   <= s_ph_r;
      m_fac_r  <= s_fac_r;
      m_prod_r <= {8'd0, master} * {8'd0, s_fac_r};
    end
  end

  assign vld_out = m_vld_r;
  assign factor  = m_fac_r;
  assign drive   = ble_pkg::div255(m_prod_r);
  assign phase   = m_ph_r;

endmodule

// ===== hdl/breathing_led_envelope_unit.sv =====
// Breathing LED envelope top level: configuration registers, modulo cell
// chain, shaper pipeline and output register. Depends on ble_pkg and all
// ble_* modules.
//
// Usage:
//   The input channel (in_valid, in_stall, in_elapsed_ms) takes one time
//   sample per request. The result channel (out_valid, out_stall and the
//   six field ports) returns one result per request, in order.
//   Configuration is written through cfg_we, cfg_idx, cfg_wdata while the
//   block is idle; writes take effect on the next request.
//   Throughput: one request per cycle while not stalled. Pipeline: 32 modulo
//   cells, one decode stage, nine divider stages, one shaping stage and one
//   scaling stage from acceptance to out_valid; the modulo chain, one
//   conditional subtract per cell, is the longest part of it.
//   The whole pipeline advances together; when out_stall holds a valid
//   result, everything stops and in_stall rises. An empty output slot lets
//   the pipeline advance even when the receiver stalls.
//   Reset (rst_n low, synchronous) clears all valid bits and loads the
//   register defaults: rise 1500, hold high 500, fall 1500, hold low 500,
//   master 255, color 0.
module breathing_led_envelope_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ble_pkg::TimeW-1:0]     in_elapsed_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ble_pkg::LvlW-1:0]      out_envelope_factor,
  output logic [ble_pkg::LvlW-1:0]      out_drive_level,
  output logic [1:0]                    out_phase_now,
  output logic [ble_pkg::LvlW-1:0]      out_out_red,
  output logic [ble_pkg::LvlW-1:0]      out_out_green,
  output logic [ble_pkg::LvlW-1:0]      out_out_blue,
  input  logic                          cfg_we,
  input  logic [ble_pkg::CfgAw-1:0]     cfg_idx,
  input  logic [ble_pkg::DurW-1:0]      cfg_wdata
);

  localparam int N = ble_pkg::NumCells;

  logic [ble_pkg::DurW-1:0] rise_r, high_r, fall_r, low_r;
  logic [ble_pkg::LvlW-1:0] master_r, red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r   <= ble_pkg::RiseRst;
      high_r   <= ble_pkg::HighRst;
      fall_r   <= ble_pkg::FallRst;
      low_r    <= ble_pkg::LowRst;
      master_r <= ble_pkg::MasterRst;
      red_r    <= '0;
      green_r  <= '0;
      blue_r   <= '0;
    end else if (cfg_we) begin
      unique case (ble_pkg::cfg_idx_t'(cfg_idx))
        ble_pkg::REG_RISE:   rise_r   <= cfg_wdata;
        ble_pkg::REG_HIGH:   high_r   <= cfg_wdata;
        ble_pkg::REG_FALL:   fall_r   <= cfg_wdata;
        ble_pkg::REG_LOW:    low_r    <= cfg_wdata;
        ble_pkg::REG_MASTER: master_r <= cfg_wdata[ble_pkg::LvlW-1:0];
        ble_pkg::REG_RED:    red_r    <= cfg_wdata[ble_pkg::LvlW-1:0];
        ble_pkg::REG_GREEN:  green_r  <= cfg_wdata[ble_pkg::LvlW-1:0];
        default:             blue_r   <= cfg_wdata[ble_pkg::LvlW-1:0];
      endcase
    end
  end

  logic [ble_pkg::TotW-1:0] tot;
  assign tot = {2'b00, rise_r} + {2'b00, high_r} + {2'b00, fall_r} + {2'b00, low_r};

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic [N:0]                  c_vld;
  logic [ble_pkg::TimeW-1:0]   c_rem [N+1];

  assign c_vld[0] = in_valid;
  assign c_rem[0] = in_elapsed_ms;

  for (genvar i = 0; i < N; i++) begin : g_cell
    ble_mod_cell #(.Shift(N - 1 - i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (c_vld[i]),
      .adv     (adv),
      .rem_in  (c_rem[i]),
      .tot     (tot),
      .vld_out (c_vld[i+1]),
      .rem_out (c_rem[i+1])
    );
  end

  logic sh_vld;
  ble_shaper u_shaper (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (c_vld[N]),
    .adv     (adv),
    .pos     (c_rem[N][ble_pkg::TotW-1:0]),
    .rise    (rise_r),
    .high    (high_r),
    .fall    (fall_r),
    .master  (master_r),
    .vld_out (sh_vld),
    .factor  (out_envelope_factor),
    .drive   (out_drive_level),
    .phase   (out_phase_now)
  );

  assign out_valid     = sh_vld;
  assign out_out_red   = red_r;
  assign out_out_green = green_r;
  assign out_out_blue  = blue_r;

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for breathing_led_envelope_unit: random and directed time samples
// checked against an in-bench envelope predictor. Depends on ble_pkg and the RTL.
module tb;

  typedef struct packed {
    logic [7:0] factor;
    logic [7:0] drive;
    logic [1:0] phase;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } env_res_t;

  class env_scoreboard;
    int unsigned rise, hold_hi, fall, hold_lo, master, red, green, blue;
    env_res_t pending[$];
    int errors;
    int checked;

    function new();
      rise = 1500; hold_hi = 500; fall = 1500; hold_lo = 500;
      master = 255; red = 0; green = 0; blue = 0;
      errors = 0; checked = 0;
    endfunction

    function int unsigned ramp(int unsigned p);
      int unsigned q;
      q = (p * p) / 255;
      return 5 + (q * 250) / 255;
    endfunction

    function void note_sample(logic [31:0] t);
      longint unsigned e1, e2, e3, tot, pos, tt;
      int unsigned f;
      env_res_t r;
      tt = {32'd0, t};
      e1 = rise; e2 = e1 + hold_hi; e3 = e2 + fall; tot = e3 + hold_lo;
      pos = (tot != 0) ? (tt % tot) : 0;
      if (pos < e1) begin
        f = ramp(32'((pos * 255) / rise)); r.phase = ble_pkg::PH_RISE;
      end else if (pos < e2) begin
        f = 255; r.phase = ble_pkg::PH_HIGH;
      end else if (pos < e3) begin
        f = ramp(32'(255 - ((pos - e2) * 255) / fall)); r.phase = ble_pkg::PH_FALL;
      end else begin
        f = 5; r.phase = ble_pkg::PH_LOW;
      end
      r.factor = 8'(f);
      r.drive = 8'((master * f) / 255);
      r.red = 8'(red); r.green = 8'(green); r.blue = 8'(blue);
      pending.push_back(r);
    endfunction

    function void check_result(env_res_t a);
      env_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.factor !== e.factor) begin
        $error("envelope_factor exp %0d got %0d", e.factor, a.factor); errors++;
      end
      if (a.drive !== e.drive) begin
        $error("drive_level exp %0d got %0d", e.drive, a.drive); errors++;
      end
      if (a.phase !== e.phase) begin
        $error("phase_now exp %0d got %0d", e.phase, a.phase); errors++;
      end
      if (a.red !== e.red) begin
        $error("out_red exp %0d got %0d", e.red, a.red); errors++;
      end
      if (a.green !== e.green) begin
        $error("out_green exp %0d got %0d", e.green, a.green); errors++;
      end
      if (a.blue !== e.blue) begin
        $error("out_blue exp %0d got %0d", e.blue, a.blue); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [31:0] in_elapsed_ms = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [7:0] out_envelope_factor, out_drive_level, out_out_red, out_out_green;
  logic [7:0] out_out_blue;
  logic [1:0] out_phase_now;
  logic cfg_we = 0;
  logic [ble_pkg::CfgAw-1:0] cfg_idx = 0;
  logic [ble_pkg::DurW-1:0] cfg_wdata = 0;

  env_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int sent = 0;

  always #1 clk = ~clk;

  breathing_led_envelope_unit dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_envelope_factor, out_drive_level, out_phase_now,
                       out_out_red, out_out_green, out_out_blue});
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic write_reg(ble_pkg::cfg_idx_t idx, int unsigned val);
    cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= ble_pkg::DurW'(val);
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      ble_pkg::REG_RISE:   sb.rise = val & 16'hffff;
      ble_pkg::REG_HIGH:   sb.hold_hi = val & 16'hffff;
      ble_pkg::REG_FALL:   sb.fall = val & 16'hffff;
      ble_pkg::REG_LOW:    sb.hold_lo = val & 16'hffff;
      ble_pkg::REG_MASTER: sb.master = val & 8'hff;
      ble_pkg::REG_RED:    sb.red = val & 8'hff;
      ble_pkg::REG_GREEN:  sb.green = val & 8'hff;
      default:             sb.blue = val & 8'hff;
    endcase
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send_sample(logic [31:0] t);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_elapsed_ms <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(t);
    sent++;
  endtask

  task automatic end_burst();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic set_timing(int unsigned r, int unsigned h, int unsigned f, int unsigned l);
    write_reg(ble_pkg::REG_RISE, r); write_reg(ble_pkg::REG_HIGH, h);
    write_reg(ble_pkg::REG_FALL, f); write_reg(ble_pkg::REG_LOW, l);
  endtask

  task automatic set_colors();
    write_reg(ble_pkg::REG_MASTER, $urandom_range(255));
    write_reg(ble_pkg::REG_RED, $urandom_range(255));
    write_reg(ble_pkg::REG_GREEN, $urandom_range(255));
    write_reg(ble_pkg::REG_BLUE, $urandom_range(255));
  endtask

  task automatic rand_phase(int n);
    int unsigned tot;
    logic [31:0] t;
    tot = sb.rise + sb.hold_hi + sb.fall + sb.hold_lo;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0 || tot == 0) t = $urandom();
      else t = $urandom_range(tot * 3);
      send_sample(t);
    end
    end_burst();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // reset values, phase boundaries
    send_sample(0); send_sample(1499); send_sample(1500); send_sample(1999);
    send_sample(2000); send_sample(3499); send_sample(3500); send_sample(3999);
    send_sample(4000); send_sample(32'hffffffff); send_sample(32'h80000000);
    end_burst();
    drain();
    set_timing(0, 0, 0, 0);
    write_reg(ble_pkg::REG_MASTER, 0);
    send_sample(12345); send_sample(32'hffffffff);
    end_burst();
    drain();
    set_timing(1, 0, 1, 0);
    write_reg(ble_pkg::REG_MASTER, 255); write_reg(ble_pkg::REG_RED, 255);
    write_reg(ble_pkg::REG_GREEN, 255); write_reg(ble_pkg::REG_BLUE, 255);
    send_sample(0); send_sample(1); send_sample(2); send_sample(32'hffffffff);
    end_burst();
    drain();
    set_timing(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_sample(65534); send_sample(65535); send_sample(131070);
    send_sample(196605); send_sample(262139); send_sample(32'hffffffff);
    end_burst();
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 56; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 56; end
        default: begin send_idle = 38; recv_stall = 38; end
      endcase
      case (ph)
        0: set_timing(1500, 500, 1500, 500);
        1: set_timing($urandom_range(1, 20), 0, $urandom_range(1, 20), 0);
        2: set_timing($urandom_range(1, 65535), $urandom_range(65535),
                      $urandom_range(1, 65535), $urandom_range(65535));
        3: set_timing(0, $urandom_range(300), 0, $urandom_range(300));
        default: set_timing($urandom_range(1, 4000), $urandom_range(2000),
                            $urandom_range(1, 4000), $urandom_range(2000));
      endcase
      set_colors();
      rand_phase(100);
      drain();
    end
    send_idle = 0; recv_stall = 0;
    $display("tb: %0d samples sent, %0d results checked over 8 timing/idle phases",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end
endmodule
